// File: src/swll_pkg.sv
`default_nettype none

package swll_pkg;

	// Number of launch stamps kept in the table.
	localparam int TABLE_DEPTH = 128;

	// Table index and fill count widths. The fill count must be able to hold
	// the depth itself.
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Width used to compare the count against 8-bit quantities.
	localparam int SAT_W = (CNT_W > 8) ? CNT_W : 8;

	localparam int TIME_W   = 32;
	localparam int WINDOW_W = 16;
	localparam int MAX_W    = 8;
	localparam int RCNT_W   = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAUNCHES  = CFG_IDX_W'(1);

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(180);
	localparam logic [MAX_W-1:0]    MAX_RESET    = MAX_W'(5);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;   // capture the request and clear the accumulators
		logic issue;   // read the next table entry
		logic commit;  // decide, update the table and load the result
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last_addr;  // the entry being read now is the last one
		logic out_free;   // the result register can take a new result
	} sts_t;

endpackage

`default_nettype wire

// File: src/swll_ctrl.sv
`default_nettype none

module swll_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire swll_pkg::sts_t sts,
	output swll_pkg::cmd_t     cmd
);
	import swll_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.last_addr) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_LAST: begin
			end
			ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/swll_dp.sv
`default_nettype none

module swll_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire swll_pkg::cmd_t                   cmd,
	output swll_pkg::sts_t                        sts,
	input  wire logic [swll_pkg::TIME_W-1:0]      now_time,
	input  wire logic                             cfg_valid,
	input  wire logic [swll_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swll_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  granted,
	output logic [swll_pkg::RCNT_W-1:0]           recent_count
);
	import swll_pkg::*;

	logic [WINDOW_W-1:0] window_q;
	logic [MAX_W-1:0]    max_q;

	// Entries below the fill count are valid; entries fill strictly in order.
	logic [CNT_W-1:0]    fill_q;

	logic [TIME_W-1:0]   stamp_mem [TABLE_DEPTH];

	logic [TIME_W-1:0]   now_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic [TIME_W-1:0]   rd_data_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                rd_vld_s1;

	logic [CNT_W-1:0]    count_q;
	logic [TIME_W-1:0]   min_stamp_q;
	logic [IDX_W-1:0]    min_idx_q;

	logic                out_valid_q;
	logic                granted_q;
	logic [RCNT_W-1:0]   recent_count_q;

	logic                entry_live;
	logic                in_window;
	logic                take_min;
	logic [SAT_W-1:0]    count_ext;
	logic                grant;
	logic [IDX_W-1:0]    victim;
	logic [RCNT_W-1:0]   count_sat;

	assign entry_live = CNT_W'(rd_idx_s1) < fill_q;
	assign in_window  = ({1'b0, rd_data_s1} + {{(TIME_W + 1 - WINDOW_W){1'b0}}, window_q})
		> {1'b0, now_q};
	assign take_min   = (rd_idx_s1 == '0) || (rd_data_s1 < min_stamp_q);

	assign count_ext  = SAT_W'(count_q);
	assign grant      = count_ext < SAT_W'(max_q);
	assign victim     = (fill_q < CNT_W'(TABLE_DEPTH)) ? fill_q[IDX_W-1:0] : min_idx_q;
	assign count_sat  = (count_ext > SAT_W'(255)) ? RCNT_W'(255) : count_ext[RCNT_W-1:0];

	assign sts.last_addr = rd_addr_q == IDX_W'(TABLE_DEPTH - 1);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			max_q    <= MAX_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_WINDOW_LENGTH) begin
				window_q <= cfg_data[WINDOW_W-1:0];
			end else if (cfg_index == CFG_MAX_LAUNCHES) begin
				max_q <= cfg_data[MAX_W-1:0];
			end
		end
	end

	// Stamp table: one read or one write per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= stamp_mem[rd_addr_q];
		end
		if (cmd.commit && grant) begin
			stamp_mem[victim] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
		if (cmd.start) begin
			now_q <= now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			min_stamp_q <= '0;
			min_idx_q   <= '0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.start) begin
				rd_addr_q <= '0;
				count_q   <= '0;
			end else if (cmd.issue) begin
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			end
			if (rd_vld_s1) begin
				if (entry_live && in_window) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (take_min) begin
					min_stamp_q <= rd_data_s1;
					min_idx_q   <= rd_idx_s1;
				end
			end
			if (cmd.commit && grant && (fill_q < CNT_W'(TABLE_DEPTH))) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q      <= grant;
			recent_count_q <= count_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign recent_count = recent_count_q;

endmodule

`default_nettype wire

// File: src/sliding_window_launch_limiter.sv
// Sliding-window launch limiter. Each transfer on the input channel is one
// launch request carrying the current time (now_time). The block keeps a table
// of recent launch stamps and counts those whose stamp plus window_length lies
// later than now_time, using a 33-bit sum that cannot wrap. If that count is
// below max_launches, the request is granted and the stamp is recorded: in
// the next unused entry while the table is filling, and once it is full over
// the lowest-index entry holding the oldest stamp. Every request gives exactly
// one result transfer with granted and recent_count, the count taken before
// the request, saturated at 255. Between its input transfer and its result a
// request goes through the walk over the stamp table (128 entries by default),
// which reads one entry per cycle through a single memory port, then a drain
// of the registered read, then a step that decides and writes back once the
// result register is free. The input is taken again in the cycle after the
// result is loaded; a result waiting at the output only holds the block when
// the next result is ready to be loaded. Configuration writes are always
// accepted (cfg_ready is tied high): index 0 sets window_length, index 1 sets
// max_launches, other indexes are ignored. Write them only while no request is
// in flight. After reset the table is empty and no clearing pass is needed.

`default_nettype none

module sliding_window_launch_limiter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [swll_pkg::TIME_W-1:0]      now_time,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  granted,
	output logic [swll_pkg::RCNT_W-1:0]           recent_count,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [swll_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swll_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import swll_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Register writes never need to wait.
	assign cfg_ready = 1'b1;

	// The controller sequences one request at a time: capture, table walk,
	// drain of the last read, then decision and write-back.
	swll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the stamp table with its fill
	// count, the counting and oldest-entry search, and the result register.
	swll_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.now_time     (now_time),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.recent_count (recent_count)
	);

endmodule

`default_nettype wire

// File: src/swll_checker.sv
`default_nettype none

module swll_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic                             in_ready,
	input  wire logic [swll_pkg::TIME_W-1:0]      now_time,
	input  wire logic                             out_valid,
	input  wire logic                             out_ready,
	input  wire logic                             granted,
	input  wire logic [swll_pkg::RCNT_W-1:0]      recent_count,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_ready,
	input  wire logic [swll_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swll_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import swll_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(recent_count))
		else $error("result changed while stalled");

	// Only one request is worked on at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// A new result appears only while a request is being processed.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in flight");

	// Early in the table walk after a transfer, the input is still refused.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !in_ready)
		else $error("request finished too early");

	// Configuration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind sliding_window_launch_limiter swll_checker u_swll_checker (.*);

`default_nettype wire

// File: verif/sliding_window_launch_limiter_test.sv
// One verdict of the limiter: the fields of a single result transfer.
typedef struct packed {
	logic                              granted;
	logic [swll_pkg::RCNT_W-1:0]       recent_count;
} launch_verdict_t;

// Tracks the launch table alongside the block and keeps the verdicts that are
// still owed by it, oldest first.
class launch_tracker;
	logic [swll_pkg::TIME_W-1:0]   stamps [swll_pkg::TABLE_DEPTH];
	bit                            occupied [swll_pkg::TABLE_DEPTH];
	logic [swll_pkg::WINDOW_W-1:0] window_len;
	logic [swll_pkg::MAX_W-1:0]    launch_cap;
	launch_verdict_t               pending_verdicts [$];
	int                            mismatches;

	function new();
		foreach (stamps[i]) begin
			stamps[i]   = '0;
			occupied[i] = 1'b0;
		end
		window_len = swll_pkg::WINDOW_RESET;
		launch_cap = swll_pkg::MAX_RESET;
		mismatches = 0;
	endfunction

	function void write_register(logic [swll_pkg::CFG_IDX_W-1:0] idx,
			logic [swll_pkg::CFG_DATA_W-1:0] data);
		if (idx == swll_pkg::CFG_WINDOW_LENGTH) begin
			window_len = data[swll_pkg::WINDOW_W-1:0];
		end else if (idx == swll_pkg::CFG_MAX_LAUNCHES) begin
			launch_cap = data[swll_pkg::MAX_W-1:0];
		end
	endfunction

	// Decides one request the way the block must, updates the table and
	// queues the verdict.
	function void note_request(logic [swll_pkg::TIME_W-1:0] stamp_now);
		int                          live;
		int                          victim;
		bit                          found_free;
		logic [swll_pkg::TIME_W:0]   expiry;
		launch_verdict_t             verdict;
		live = 0;
		for (int i = 0; i < swll_pkg::TABLE_DEPTH; i++) begin
			// The sum is one bit wider than a stamp, so it cannot wrap.
			expiry = {1'b0, stamps[i]} + (swll_pkg::TIME_W + 1)'(window_len);
			if (occupied[i] && expiry > {1'b0, stamp_now})
				live++;
		end
		verdict.granted = (live < launch_cap);
		verdict.recent_count = (live > int'({swll_pkg::RCNT_W{1'b1}})) ?
			{swll_pkg::RCNT_W{1'b1}} : swll_pkg::RCNT_W'(live);
		if (verdict.granted) begin
			victim = 0;
			found_free = 1'b0;
			for (int i = 0; i < swll_pkg::TABLE_DEPTH && !found_free; i++) begin
				if (!occupied[i]) begin
					victim = i;
					found_free = 1'b1;
				end
			end
			// With the table full, the lowest index holding the oldest stamp goes.
			if (!found_free) begin
				for (int i = 1; i < swll_pkg::TABLE_DEPTH; i++) begin
					if (stamps[i] < stamps[victim])
						victim = i;
				end
			end
			stamps[victim] = stamp_now;
			occupied[victim] = 1'b1;
		end
		pending_verdicts.push_back(verdict);
	endfunction

	function void check_verdict(logic got_granted, logic [swll_pkg::RCNT_W-1:0] got_count,
			realtime at_ns);
		launch_verdict_t want;
		if (pending_verdicts.size() == 0) begin
			$display("%0.3f ns: result with no request outstanding: granted=%0b recent_count=%0d",
				at_ns, got_granted, got_count);
			mismatches++;
		end else begin
			want = pending_verdicts.pop_front();
			if (got_granted !== want.granted) begin
				$display("%0.3f ns: granted expected %0b actual %0b",
					at_ns, want.granted, got_granted);
				mismatches++;
			end
			if (got_count !== want.recent_count) begin
				$display("%0.3f ns: recent_count expected %0d actual %0d",
					at_ns, want.recent_count, got_count);
				mismatches++;
			end
		end
	endfunction
endclass

module sliding_window_launch_limiter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swll_pkg::*;

	localparam int RESET_CYCLES     = 5;
	localparam int BURST_MAX        = 11;
	// Long enough for one result to sit at the output and the next one to
	// finish its walk behind it, so the block has to refuse new requests.
	localparam int LONG_HOLD_CYCLES = 1200;
	// A comfortable margin over the time that one request needs.
	localparam int DRAIN_CYCLES     = 2 * (TABLE_DEPTH + 3);
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_MAX_LAUNCHES + 1'b1;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [TIME_W-1:0]      now_time     = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic                   granted;
	logic [RCNT_W-1:0]      recent_count;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	launch_tracker          tracker;
	logic [TIME_W-1:0]      launch_clock = '0;
	int                     quiet_cycles = 0;
	// calm_tail and hold_off_request are shared with the receiver process; sender_gappy is used by the stimulus only.
	bit                     sender_gappy     = 1'b1;
	bit                     calm_tail        = 1'b0;
	bit                     hold_off_request = 1'b0;

	sliding_window_launch_limiter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.recent_count (recent_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Everything is sampled right at the rising edge, before any of the
	// nonblocking updates of that edge land, so each transfer is seen exactly
	// as the block sees it. Requests are noted before results are checked,
	// although a request can never be answered at the edge that takes it.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.note_request(now_time);
		if (out_valid && out_ready)
			tracker.check_verdict(granted, recent_count, $realtime);
		if (cfg_valid && cfg_ready)
			tracker.write_register(cfg_index, cfg_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		// No transfer of any kind for this long means the block has hung.
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sliding_window_launch_limiter_test NOT OK");
			$finish;
		end
	end

	// Result side. Ready drops in short random bursts, sometimes stays up for
	// long stretches, and once holds off for a long time so that the block
	// fills up and stalls its input. No stalls at all once the calm tail starts.
	initial begin
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!calm_tail && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(150, 400)) @(posedge clk);
			else
				repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Offers one launch request and returns at the edge where its transfer
	// happens. Valid is left high so that the next request can follow at once.
	// A gap is a chain of short bursts, so its end can land anywhere in the
	// block's walk over the table, including the cycles where it is ready.
	task automatic offer_launch(input logic [TIME_W-1:0] stamp_val);
		if (!calm_tail && sender_gappy && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14))
				repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_time <= stamp_val;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drops valid and waits until every verdict owed has come back. One edge
	// passes first so that the last request has surely been noted.
	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes both limits back to back. The upper byte of the max_launches word
	// carries noise, which the block must drop. Now and then a write to an
	// unmapped index goes along, which must change nothing.
	task automatic program_limits(input logic [WINDOW_W-1:0] win,
			input logic [MAX_W-1:0] cap);
		logic [CFG_DATA_W-1:0] cap_word;
		cap_word = CFG_DATA_W'($urandom);
		cap_word[MAX_W-1:0] = cap;
		write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(win));
		write_reg(CFG_MAX_LAUNCHES, cap_word);
		if ($urandom_range(0, 1) == 1)
			write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, {CFG_IDX_W{1'b1}})),
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Mostly small steps forward, scaled so that the window fills up, with
	// repeated stamps for ties, steps backwards, long steps that let entries
	// expire and now and then a jump to anywhere in the 32-bit range.
	function automatic logic [TIME_W-1:0] next_launch_time(input logic [TIME_W-1:0] cur,
			input int win, input int step_hi);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return cur + TIME_W'($urandom_range(0, step_hi));
		else if (pick < 72)
			return cur;
		else if (pick < 84)
			return cur - TIME_W'($urandom_range(0, 2 * win + 1));
		else if (pick < 94)
			return cur + TIME_W'($urandom_range(0, 4 * win + 4));
		else
			return $urandom;
	endfunction

	task automatic run_phase(input int win, input int cap, input int step_hi, input int items);
		wait_for_quiet();
		program_limits(WINDOW_W'(win), MAX_W'(cap));
		sender_gappy = ($urandom_range(0, 3) != 0);
		repeat (items) begin
			launch_clock = next_launch_time(launch_clock, win, step_hi);
			offer_launch(launch_clock);
		end
	endtask

	initial begin
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits (window 180, five launches). Stamp zero in a fresh entry
		// must not count, the window edge is exclusive at 180, and the sixth
		// launch inside the window is refused.
		offer_launch(32'd0);
		offer_launch(32'd0);
		offer_launch(32'd100);
		offer_launch(32'd179);
		offer_launch(32'd179);
		offer_launch(32'd180);
		offer_launch(32'd200);
		offer_launch(32'd200);

		// Zero window with time running backwards: only stamps later than now
		// are counted.
		wait_for_quiet();
		program_limits(16'd0, 8'd3);
		offer_launch(32'd150);
		offer_launch(32'd199);
		offer_launch(32'd500);

		// Zero launches allowed: everything is refused and the table stays put.
		wait_for_quiet();
		program_limits({WINDOW_W{1'b1}}, 8'd0);
		offer_launch({TIME_W{1'b1}});
		offer_launch(32'd0);

		// Widest window and the full table as limit, with stamps at the top of
		// the range where stamp plus window needs the extra bit.
		wait_for_quiet();
		program_limits({WINDOW_W{1'b1}}, MAX_W'(TABLE_DEPTH));
		offer_launch(32'hFFFF_FFF0);
		offer_launch({TIME_W{1'b1}});
		offer_launch({TIME_W{1'b1}});
		offer_launch(32'h7FFF_FFFF);
		offer_launch(32'h8000_0000);
		offer_launch(32'hAAAA_AAAA);
		offer_launch(32'h5555_5555);

		// Random part. The first phase overruns the table so that the oldest
		// stamp gets replaced; the second carries the long hold-off.
		run_phase(1000, TABLE_DEPTH, 15, 260);
		hold_off_request = 1'b1;
		run_phase({WINDOW_W{1'b1}}, TABLE_DEPTH, 1000, 200);
		run_phase(1, TABLE_DEPTH, 2, 180);
		run_phase(0, 4, 3, 150);
		run_phase(180, 5, 60, 180);
		run_phase(300, {MAX_W{1'b1}}, 5, 180);
		run_phase(50, 1, 40, 150);
		run_phase({WINDOW_W{1'b1}}, 0, 1000, 80);
		calm_tail = 1'b1;
		run_phase(7, 64, 1, 200);

		// Let the last verdicts arrive, then watch a while for stray results.
		wait_for_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
			$display("sliding_window_launch_limiter_test OK");
		else
			$display("sliding_window_launch_limiter_test NOT OK");
		$finish;
	end

endmodule
